// File: rtl/core/chip8_pkg.sv
package chip8_pkg;

	// Fixed machine geometry
	localparam int MEM_BYTES   = 4096;
	localparam int STACK_DEPTH = 16;
	localparam int SCR_WIDTH   = 64;
	localparam int SCR_HEIGHT  = 32;

	localparam logic [11:0] FONT_BASE     = 12'h050;
	localparam logic [11:0] PROGRAM_START = 12'h200;
	localparam int          FONT_BYTES    = 80;

	// Command codes carried in the slave tuser
	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_EXEC  = 3'd1;
	localparam logic [2:0] CMD_KEY   = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_PIXEL = 3'd4;

	// Major opcode nibbles
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	// ALU sub-operations (8xyN)
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// Low bytes of the system, key and misc groups
	localparam logic [11:0] SYS_CLS = 12'h0E0;
	localparam logic [11:0] SYS_RET = 12'h0EE;
	localparam logic [7:0]  KEY_SKP  = 8'h9E;
	localparam logic [7:0]  KEY_SKNP = 8'hA1;
	localparam logic [7:0]  MSC_GDT  = 8'h07;
	localparam logic [7:0]  MSC_WKEY = 8'h0A;
	localparam logic [7:0]  MSC_SDT  = 8'h15;
	localparam logic [7:0]  MSC_SST  = 8'h18;
	localparam logic [7:0]  MSC_ADDI = 8'h1E;
	localparam logic [7:0]  MSC_FONT = 8'h29;
	localparam logic [7:0]  MSC_BCD  = 8'h33;
	localparam logic [7:0]  MSC_STR  = 8'h55;
	localparam logic [7:0]  MSC_LDR  = 8'h65;

	localparam logic [7:0] FONT_GLYPHS [FONT_BYTES] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
	};

	// Reset contents of one main memory byte
	function automatic logic [7:0] reset_byte(input logic [11:0] addr);
		logic [11:0] ofs;
		ofs = addr - FONT_BASE;
		if (addr >= FONT_BASE && ofs < 12'(FONT_BYTES))
			return FONT_GLYPHS[ofs[6:0]];
		return 8'h00;
	endfunction

endpackage

// File: rtl/core/chip8_interpreter_core.sv
// Channel  Dir  Width  Contents
// s_axis   in   48+3   tdata: load_address, load_data, rand_value, key_number,
//                      key_pressed, pixel_column, pixel_row; tuser: command
// m_axis   out  40     tdata: program_counter, index_value, waiting_for_key,
//                      sound_active, delay_value, pixel_value
//
// One command at a time. Sprite draw reads and writes back each row (one
// sprite and display read per row); clear screen, BCD and Fx55/Fx65 step
// through display rows, digits or registers. After reset a clearing pass over
// all 4096 main memory bytes writes zeros and the font into them and clears
// the display; no command is taken meanwhile.
// A result waits in an output register; the core holds while it is not taken.
module chip8_interpreter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] load_address, [19:12] load_data, [27:20] rand_value,
	// [31:28] key_number, [32] key_pressed, [38:33] pixel_column,
	// [43:39] pixel_row, [47:44] zero
	input  logic [47:0] s_tdata,
	// [2:0] command
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] program_counter, [27:12] index_value, [28] waiting_for_key,
	// [29] sound_active, [37:30] delay_value, [38] pixel_value, [39] zero
	output logic [39:0] m_tdata
);
	import chip8_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_F1   = 4'd2;
	localparam logic [3:0] ST_F2   = 4'd3;
	localparam logic [3:0] ST_RY   = 4'd4;
	localparam logic [3:0] ST_EXEC = 4'd5;
	localparam logic [3:0] ST_DRA  = 4'd6;
	localparam logic [3:0] ST_DRB  = 4'd7;
	localparam logic [3:0] ST_CLS  = 4'd8;
	localparam logic [3:0] ST_BCD  = 4'd9;
	localparam logic [3:0] ST_ST55 = 4'd10;
	localparam logic [3:0] ST_LD65 = 4'd11;
	localparam logic [3:0] ST_LDW  = 4'd12;
	localparam logic [3:0] ST_PIX  = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	logic [3:0]  state_q;
	logic [11:0] cnt_q;
	logic [11:0] pc_q;
	logic [15:0] i_q;
	logic [3:0]  sp_q;
	logic [7:0]  dt_q, st_q;
	logic [15:0] keys_q;
	logic        wait_q;
	logic [3:0]  wtgt_q;
	logic [7:0]  v_q [16];
	logic [11:0] stack_q [STACK_DEPTH];
	logic [7:0]  hi_q, lo_q, vx_q, vy_q, rnd_q;
	logic [5:0]  col_q;
	logic        pix_q, hit_q;
	logic [7:0]  bcd_h_q, bcd_t_q, bcd_u_q;
	logic        ld_v_s1;
	logic [3:0]  ld_idx_s1;
	logic        out_v_q;
	logic [39:0] out_q;

	// Memories
	logic [7:0]  mem [MEM_BYTES];
	logic [7:0]  mem_rdata;
	logic [11:0] mem_addr;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic [63:0] fb [SCR_HEIGHT];
	logic [63:0] fb_rdata;
	logic [4:0]  fb_addr;
	logic        fb_we;
	logic [63:0] fb_wd;

	// Input unpacking
	logic        in_acc;
	logic [11:0] in_laddr;
	logic [7:0]  in_ldata, in_rnd;
	logic [3:0]  in_key;
	logic        in_press;
	logic [5:0]  in_col;
	logic [4:0]  in_row;

	assign in_acc   = s_tvalid & s_tready;
	assign in_laddr = s_tdata[11:0];
	assign in_ldata = s_tdata[19:12];
	assign in_rnd   = s_tdata[27:20];
	assign in_key   = s_tdata[31:28];
	assign in_press = s_tdata[32];
	assign in_col   = s_tdata[38:33];
	assign in_row   = s_tdata[43:39];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Instruction fields
	logic [3:0]  op, x, y, n;
	logic [7:0]  kk;
	logic [11:0] nnn, pcn, pcs, ofs_addr;
	logic [4:0]  draw_row;

	assign op       = hi_q[7:4];
	assign x        = hi_q[3:0];
	assign y        = lo_q[7:4];
	assign n        = lo_q[3:0];
	assign kk       = lo_q;
	assign nnn      = {hi_q[3:0], lo_q};
	assign pcn      = pc_q + 12'd2;
	assign pcs      = pc_q + 12'd4;
	assign ofs_addr = i_q[11:0] + cnt_q;
	assign draw_row = vy_q[4:0] + cnt_q[4:0];

	// Single register-file read port
	logic [3:0] v_rd_idx;
	logic [7:0] v_rd;

	always_comb begin
		case (state_q)
			ST_F2:   v_rd_idx = x;
			ST_RY:   v_rd_idx = (op == OP_JPV0) ? 4'd0 : y;
			default: v_rd_idx = cnt_q[3:0];
		endcase
	end
	assign v_rd = v_q[v_rd_idx];

	// ALU results
	logic [8:0] sum9, sub9, sbn9;
	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
	assign sub9 = {1'b0, vx_q} - {1'b0, vy_q};
	assign sbn9 = {1'b0, vy_q} - {1'b0, vx_q};

	// BCD digits of Vx: hundreds by compare, tens by reciprocal multiply
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_r8;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t;
	logic [6:0]  bcd_u;

	always_comb begin
		if (vx_q >= 8'd200) begin
			bcd_h  = 2'd2;
			bcd_r8 = vx_q - 8'd200;
		end else if (vx_q >= 8'd100) begin
			bcd_h  = 2'd1;
			bcd_r8 = vx_q - 8'd100;
		end else begin
			bcd_h  = 2'd0;
			bcd_r8 = vx_q;
		end
	end
	assign bcd_prod = {8'b0, bcd_r8[6:0]} * 15'd205;
	assign bcd_t    = bcd_prod[14:11];
	assign bcd_u    = bcd_r8[6:0] - {bcd_t, 3'b0} - {2'b0, bcd_t, 1'b0};

	// Sprite row mask, MSB of the byte at column x0, wrapping
	logic [7:0]   spr_rev;
	logic [127:0] spr_dbl;
	logic [63:0]  spr_mask;

	always_comb begin
		for (int j = 0; j < 8; j++)
			spr_rev[j] = mem_rdata[7 - j];
	end
	assign spr_dbl  = {56'b0, spr_rev, 56'b0, spr_rev} << vx_q[5:0];
	assign spr_mask = spr_dbl[127:64];

	// Main memory port select
	always_comb begin
		mem_addr = pc_q;
		mem_we   = 1'b0;
		mem_wd   = v_rd;
		case (state_q)
			ST_CLR: begin
				mem_addr = cnt_q;
				mem_we   = 1'b1;
				mem_wd   = reset_byte(cnt_q);
			end
			ST_IDLE: begin
				if (s_tuser == CMD_LOAD) begin
					mem_addr = in_laddr;
					mem_we   = in_acc;
					mem_wd   = in_ldata;
				end
			end
			ST_F1: mem_addr = pc_q + 12'd1;
			ST_BCD: begin
				mem_addr = ofs_addr;
				mem_we   = 1'b1;
				case (cnt_q[1:0])
					2'd0:    mem_wd = bcd_h_q;
					2'd1:    mem_wd = bcd_t_q;
					default: mem_wd = bcd_u_q;
				endcase
			end
			ST_ST55: begin
				mem_addr = ofs_addr;
				mem_we   = 1'b1;
			end
			ST_LD65, ST_DRA: mem_addr = ofs_addr;
			default: ;
		endcase
	end

	// Display memory port select
	always_comb begin
		fb_addr = draw_row;
		fb_we   = 1'b0;
		fb_wd   = '0;
		case (state_q)
			ST_CLR, ST_CLS: begin
				fb_addr = cnt_q[4:0];
				fb_we   = 1'b1;
			end
			ST_IDLE: fb_addr = in_row;
			ST_DRB: begin
				fb_we = 1'b1;
				fb_wd = fb_rdata ^ spr_mask;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		mem_rdata <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (fb_we)
			fb[fb_addr] <= fb_wd;
		fb_rdata <= fb[fb_addr];
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			cnt_q     <= '0;
			pc_q      <= PROGRAM_START;
			i_q       <= '0;
			sp_q      <= '0;
			dt_q      <= '0;
			st_q      <= '0;
			keys_q    <= '0;
			wait_q    <= 1'b0;
			wtgt_q    <= '0;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
			for (int k = 0; k < STACK_DEPTH; k++) stack_q[k] <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			rnd_q     <= '0;
			col_q     <= '0;
			pix_q     <= 1'b0;
			hit_q     <= 1'b0;
			bcd_h_q   <= '0;
			bcd_t_q   <= '0;
			bcd_u_q   <= '0;
			ld_v_s1   <= 1'b0;
			ld_idx_s1 <= '0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q == 12'(MEM_BYTES - 1))
						state_q <= ST_IDLE;
				end

				ST_IDLE: begin
					if (in_acc) begin
						pix_q   <= 1'b0;
						rnd_q   <= in_rnd;
						col_q   <= in_col;
						cnt_q   <= '0;
						state_q <= ST_DONE;
						case (s_tuser)
							CMD_EXEC: begin
								if (!wait_q)
									state_q <= ST_F1;
							end
							CMD_KEY: begin
								keys_q[in_key] <= in_press;
								if (in_press && wait_q) begin
									v_q[wtgt_q] <= {4'b0, in_key};
									wait_q      <= 1'b0;
								end
							end
							CMD_TICK: begin
								if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
								if (st_q != 8'd0) st_q <= st_q - 8'd1;
							end
							CMD_PIXEL: state_q <= ST_PIX;
							default: ;
						endcase
					end
				end

				ST_PIX: begin
					pix_q   <= fb_rdata[col_q];
					state_q <= ST_DONE;
				end

				ST_F1: begin
					hi_q    <= mem_rdata;
					state_q <= ST_F2;
				end

				ST_F2: begin
					lo_q    <= mem_rdata;
					vx_q    <= v_rd;
					state_q <= ST_RY;
				end

				ST_RY: begin
					vy_q    <= v_rd;
					state_q <= ST_EXEC;
				end

				ST_EXEC: begin
					pc_q    <= pcn;
					state_q <= ST_DONE;
					cnt_q   <= '0;
					ld_v_s1 <= 1'b0;
					unique case (op)
						OP_SYS: begin
							if (nnn == SYS_CLS)
								state_q <= ST_CLS;
							else if (nnn == SYS_RET) begin
								pc_q <= stack_q[sp_q];
								sp_q <= sp_q - 4'd1;
							end
						end
						OP_JP: pc_q <= nnn;
						OP_CALL: begin
							sp_q                  <= sp_q + 4'd1;
							stack_q[sp_q + 4'd1]  <= pcn;
							pc_q                  <= nnn;
						end
						OP_SEI:  if (vx_q == kk) pc_q <= pcs;
						OP_SNEI: if (vx_q != kk) pc_q <= pcs;
						OP_SER:  if (vx_q == vy_q) pc_q <= pcs;
						OP_SNER: if (vx_q != vy_q) pc_q <= pcs;
						OP_LDI:  v_q[x] <= kk;
						OP_ADDI: v_q[x] <= vx_q + kk;
						OP_ALU: begin
							// result first, flag last so VF wins
							case (n)
								ALU_MOV: v_q[x] <= vy_q;
								ALU_OR:  v_q[x] <= vx_q | vy_q;
								ALU_AND: v_q[x] <= vx_q & vy_q;
								ALU_XOR: v_q[x] <= vx_q ^ vy_q;
								ALU_ADD: begin
									v_q[x]  <= sum9[7:0];
									v_q[15] <= {7'b0, sum9[8]};
								end
								ALU_SUB: begin
									v_q[x]  <= sub9[7:0];
									v_q[15] <= {7'b0, ~sub9[8]};
								end
								ALU_SHR: begin
									v_q[x]  <= {1'b0, vx_q[7:1]};
									v_q[15] <= {7'b0, vx_q[0]};
								end
								ALU_SBN: begin
									v_q[x]  <= sbn9[7:0];
									v_q[15] <= {7'b0, ~sbn9[8]};
								end
								ALU_SHL: begin
									v_q[x]  <= {vx_q[6:0], 1'b0};
									v_q[15] <= {7'b0, vx_q[7]};
								end
								default: ;
							endcase
						end
						OP_LDIX: i_q <= {4'b0, nnn};
						OP_JPV0: pc_q <= nnn + {4'b0, vy_q};
						OP_RND:  v_q[x] <= rnd_q & kk;
						OP_DRW: begin
							hit_q <= 1'b0;
							if (n == 4'd0)
								v_q[15] <= 8'd0;
							else
								state_q <= ST_DRA;
						end
						OP_KEY: begin
							if (kk == KEY_SKP && keys_q[vx_q[3:0]])
								pc_q <= pcs;
							else if (kk == KEY_SKNP && !keys_q[vx_q[3:0]])
								pc_q <= pcs;
						end
						OP_MISC: begin
							unique case (kk)
								MSC_GDT: v_q[x] <= dt_q;
								MSC_WKEY: begin
									wait_q <= 1'b1;
									wtgt_q <= x;
								end
								MSC_SDT:  dt_q <= vx_q;
								MSC_SST:  st_q <= vx_q;
								MSC_ADDI: i_q  <= i_q + {8'b0, vx_q};
								MSC_FONT: i_q  <= {4'b0, FONT_BASE} + {6'b0, vx_q, 2'b0}
									+ {8'b0, vx_q};
								MSC_BCD: begin
									bcd_h_q <= {6'b0, bcd_h};
									bcd_t_q <= {4'b0, bcd_t};
									bcd_u_q <= {1'b0, bcd_u};
									state_q <= ST_BCD;
								end
								MSC_STR: state_q <= ST_ST55;
								MSC_LDR: state_q <= ST_LD65;
								default: ;
							endcase
						end
						default: ;
					endcase
				end

				// Sprite row: issue reads, then merge and write back
				ST_DRA: state_q <= ST_DRB;
				ST_DRB: begin
					if ((fb_rdata & spr_mask) != 64'd0)
						hit_q <= 1'b1;
					if (cnt_q[3:0] == n - 4'd1) begin
						v_q[15] <= {7'b0, hit_q | ((fb_rdata & spr_mask) != 64'd0)};
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q + 12'd1;
						state_q <= ST_DRA;
					end
				end

				ST_CLS: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q[4:0] == 5'(SCR_HEIGHT - 1))
						state_q <= ST_DONE;
				end

				ST_BCD: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q[1:0] == 2'd2)
						state_q <= ST_DONE;
				end

				ST_ST55: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q[3:0] == x)
						state_q <= ST_DONE;
				end

				// Block load: each byte is written back in the cycle after its address issue
				ST_LD65: begin
					if (ld_v_s1)
						v_q[ld_idx_s1] <= mem_rdata;
					ld_v_s1   <= 1'b1;
					ld_idx_s1 <= cnt_q[3:0];
					cnt_q     <= cnt_q + 12'd1;
					if (cnt_q[3:0] == x)
						state_q <= ST_LDW;
				end
				ST_LDW: begin
					v_q[ld_idx_s1] <= mem_rdata;
					ld_v_s1        <= 1'b0;
					state_q        <= ST_DONE;
				end

				ST_DONE: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						out_q   <= {1'b0, pix_q, dt_q, (st_q != 8'd0), wait_q, i_q, pc_q};
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("command accepted during clearing pass");

	a_wait_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		($past(wait_q) && wait_q) |-> $stable(pc_q))
		else $error("program counter moved during key wait");

	a_sp_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sp_q) |-> (sp_q == $past(sp_q) + 4'd1 || sp_q == $past(sp_q) - 4'd1))
		else $error("stack pointer jumped");

	a_draw_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRA) |-> (cnt_q[11:4] == 8'd0 && cnt_q[3:0] < n))
		else $error("sprite row count out of range");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_v_q || m_tready)) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented");

endmodule
